### design/egq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_pkg
// shared widths, command and register codes, saturation helper
// ----------------------------------------------------------------------------
package egq_pkg;

   localparam int CMD_W   = 2;
   localparam int ROT_W   = 18;
   localparam int COORD_W = 32;
   localparam int AXIS_W  = 27;

   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_TEST    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BOX     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SUPPORT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_A = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_B = 1'b1;

   // radicand widths of the two root units and quotient width of the divider
   localparam int SQB_W = 88;
   localparam int SQS_W = 64;
   localparam int DIV_Q = 27;

   localparam int SAT_W = 46;
   localparam logic signed [SAT_W-1:0] SAT_MAX = 46'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_MIN = -46'sd2147483648;

   function automatic logic [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7fff_ffff;
      end else if (v < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/egq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_req_if
// query channel: valid, ready and one query transaction
// ----------------------------------------------------------------------------
interface egq_req_if
   import egq_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [ROT_W-1:0]   rot_cos;
   logic signed [ROT_W-1:0]   rot_sin;
   logic signed [COORD_W-1:0] trans_x;
   logic signed [COORD_W-1:0] trans_y;
   logic signed [COORD_W-1:0] vec_x;
   logic signed [COORD_W-1:0] vec_y;

   modport source (output valid, command, rot_cos, rot_sin, trans_x, trans_y, vec_x, vec_y,
                   input ready);
   modport sink   (input valid, command, rot_cos, rot_sin, trans_x, trans_y, vec_x, vec_y,
                   output ready);
endinterface
`default_nettype wire

### design/egq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_rsp_if
// result channel: valid, ready and one result transaction
// ----------------------------------------------------------------------------
interface egq_rsp_if
   import egq_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      inside_res;
   logic signed [COORD_W-1:0] res_x0;
   logic signed [COORD_W-1:0] res_y0;
   logic signed [COORD_W-1:0] res_x1;
   logic signed [COORD_W-1:0] res_y1;
   logic                      degenerate;

   modport source (output valid, inside_res, res_x0, res_y0, res_x1, res_y1, degenerate,
                   input ready);
   modport sink   (input valid, inside_res, res_x0, res_y0, res_x1, res_y1, degenerate,
                   output ready);
endinterface
`default_nettype wire

### design/egq_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_delay
// stallable shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
module egq_delay #(
   parameter int W = 8,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] tap_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < D; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[D-1];
endmodule
`default_nettype wire

### design/egq_mulw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_mulw
// two-stage unsigned wide multiplier built from four half-width products
// ----------------------------------------------------------------------------
module egq_mulw #(
   parameter int W = 54
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] prod
);
   localparam int H  = (W + 1) / 2;
   localparam int L  = W - H;
   localparam int PW = 2 * W;

   logic [2*H-1:0] ll_ff;
   logic [H+L-1:0] lh_ff;
   logic [H+L-1:0] hl_ff;
   logic [2*L-1:0] hh_ff;
   logic [PW-1:0]  prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= (2*H)'(op_a[H-1:0]) * (2*H)'(op_b[H-1:0]);
         lh_ff   <= (H+L)'(op_a[H-1:0]) * (H+L)'(op_b[W-1:H]);
         hl_ff   <= (H+L)'(op_a[W-1:H]) * (H+L)'(op_b[H-1:0]);
         hh_ff   <= (2*L)'(op_a[W-1:H]) * (2*L)'(op_b[W-1:H]);
         prod_ff <= PW'(ll_ff) + ((PW'(lh_ff) + PW'(hl_ff)) << H) + (PW'(hh_ff) << (2*H));
      end
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

### design/egq_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module egq_sqrt #(
   parameter int NW = 64
) (
   input  logic            clock,
   input  logic            en,
   input  logic [NW-1:0]   radicand,
   output logic [NW/2-1:0] root
);
   localparam int RW = NW / 2;

   logic [NW-1:0] n_w    [RW];
   logic [RW+1:0] rem_w  [RW];
   logic [RW-1:0] root_w [RW];

   assign n_w[0]    = radicand;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic          fits;
      logic [RW-1:0] root_nx;

      assign rem_sh  = {rem_w[i][RW-1:0], n_w[i][NW-1 -: 2]};
      assign trial   = {root_w[i], 2'b01};
      assign fits    = (rem_sh >= trial);
      assign root_nx = {root_w[i][RW-2:0], fits};

      if (i < RW - 1) begin : g_mid
         logic [NW-1:0] n_ff;
         logic [RW+1:0] rem_ff;
         logic [RW-1:0] root_ff;
         logic [RW+1:0] rem_sub;

         assign rem_sub = rem_sh - trial;

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff    <= n_w[i] << 2;
               rem_ff  <= fits ? rem_sub : rem_sh;
               root_ff <= root_nx;
            end
         end

         assign n_w[i+1]    = n_ff;
         assign rem_w[i+1]  = rem_ff;
         assign root_w[i+1] = root_ff;
      end else begin : g_last
         logic [RW-1:0] root_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff <= root_nx;
            end
         end

         assign root = root_ff;
      end
   end
endmodule
`default_nettype wire

### design/egq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egq_div
// pipelined restoring divider, one quotient bit per stage, quotient known
// to fit in QW bits
// ----------------------------------------------------------------------------
module egq_div #(
   parameter int NW = 58,
   parameter int DW = 32,
   parameter int QW = 27
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quotient
);
   logic [QW-1:0] low_w [QW];
   logic [DW-1:0] rem_w [QW];
   logic [DW-1:0] den_w [QW];
   logic [QW-1:0] quo_w [QW];

   assign low_w[0] = dividend[QW-1:0];
   assign rem_w[0] = DW'(dividend >> QW);
   assign den_w[0] = divisor;
   assign quo_w[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW:0]   remx;
      logic          fits;
      logic [QW-1:0] quo_nx;

      assign remx   = {rem_w[i], low_w[i][QW-1]};
      assign fits   = (remx >= {1'b0, den_w[i]});
      assign quo_nx = {quo_w[i][QW-2:0], fits};

      if (i < QW - 1) begin : g_mid
         logic [QW-1:0] low_ff;
         logic [DW-1:0] rem_ff;
         logic [DW-1:0] den_ff;
         logic [QW-1:0] quo_ff;
         logic [DW:0]   diff;

         assign diff = remx - {1'b0, den_w[i]};

         always_ff @(posedge clock) begin
            if (en) begin
               low_ff <= low_w[i] << 1;
               rem_ff <= fits ? diff[DW-1:0] : remx[DW-1:0];
               den_ff <= den_w[i];
               quo_ff <= quo_nx;
            end
         end

         assign low_w[i+1] = low_ff;
         assign rem_w[i+1] = rem_ff;
         assign den_w[i+1] = den_ff;
         assign quo_w[i+1] = quo_ff;
      end else begin : g_last
         logic [QW-1:0] quo_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff <= quo_nx;
            end
         end

         assign quotient = quo_ff;
      end
   end
endmodule
`default_nettype wire

### design/ellipse_geometry_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_geometry_query
// point test, bounding box and support point of a configured ellipse
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle unless a held result stalls the pipeline;
//   the 32-stage root plus 27-stage divider of the support path set the depth,
//   every path runs in parallel
// a held result freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and both semi-axis registers
module ellipse_geometry_query
   import egq_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   egq_req_if.sink              req_chan,
   egq_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [AXIS_W-1:0]    csr_wdata
);
   localparam int SQB_R   = SQB_W / 2;
   localparam int SQS_R   = SQS_W / 2;
   localparam int T_INR   = 5;
   localparam int T_LHS   = 9;
   localparam int T_IN    = 10;
   localparam int B_ROOT  = 6 + SQB_R;
   localparam int B_RES   = B_ROOT + 1;
   localparam int S_ZR    = 4;
   localparam int S_AP    = 6;
   localparam int S_ROOT  = 7 + SQS_R;
   localparam int S_QUO   = S_ROOT + DIV_Q;
   localparam int LAT     = S_QUO + 1;
   localparam int PM_W    = AXIS_W + COORD_W;
   localparam int AP_W    = AXIS_W + 31;
   localparam int SH_W    = 5;

   logic en;
   logic [LAT:1] vld_ff;
   logic [AXIS_W-1:0] axis_a_ff;
   logic [AXIS_W-1:0] axis_b_ff;
   logic degen_ab;

   assign en             = !vld_ff[LAT] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign degen_ab       = (axis_a_ff == '0) || (axis_b_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         axis_a_ff <= '0;
         axis_b_ff <= '0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-1:1], req_chan.valid};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_AXIS_A: axis_a_ff <= csr_wdata;
               CSR_AXIS_B: axis_b_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // input capture
   logic [CMD_W-1:0]          cmd1_ff;
   logic signed [ROT_W-1:0]   c1_ff, s1_ff;
   logic signed [COORD_W-1:0] tx1_ff, ty1_ff, vx1_ff, vy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= req_chan.command;
         c1_ff   <= req_chan.rot_cos;
         s1_ff   <= req_chan.rot_sin;
         tx1_ff  <= req_chan.trans_x;
         ty1_ff  <= req_chan.trans_y;
         vx1_ff  <= req_chan.vec_x;
         vy1_ff  <= req_chan.vec_y;
      end
   end

   // point test path
   logic signed [COORD_W:0]   dx2_ff, dy2_ff;
   logic signed [ROT_W-1:0]   c2_ff, s2_ff;
   logic signed [50:0]        pcx3_ff, psy3_ff, pcy3_ff, psx3_ff;
   logic signed [51:0]        lx4_ff, ly4_ff, lx_sum, ly_sum;
   logic [51:0]               xm, ym;
   logic                      inr5_ff;
   logic [AXIS_W-1:0]         x5_ff, y5_ff;
   logic [53:0]               xb6_ff, ya6_ff, ab6_ff;
   logic [107:0]              xb2_w, ya2_w, ab2_w;
   logic [108:0]              lhs9_ff;
   logic [107:0]              rhs9_ff;
   logic                      inr9_w;
   logic                      in10_ff;
   logic                      in66_w;

   assign lx_sum = 52'(pcx3_ff) + 52'(psy3_ff);
   assign ly_sum = 52'(pcy3_ff) - 52'(psx3_ff);
   assign xm     = lx4_ff[51] ? 52'(-lx4_ff) : 52'(lx4_ff);
   assign ym     = ly4_ff[51] ? 52'(-ly4_ff) : 52'(ly4_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff  <= 33'(vx1_ff) - 33'(tx1_ff);
         dy2_ff  <= 33'(vy1_ff) - 33'(ty1_ff);
         c2_ff   <= c1_ff;
         s2_ff   <= s1_ff;
         pcx3_ff <= 51'(c2_ff) * 51'(dx2_ff);
         psy3_ff <= 51'(s2_ff) * 51'(dy2_ff);
         pcy3_ff <= 51'(c2_ff) * 51'(dy2_ff);
         psx3_ff <= 51'(s2_ff) * 51'(dx2_ff);
         lx4_ff  <= lx_sum >>> FRAC_BITS;
         ly4_ff  <= ly_sum >>> FRAC_BITS;
         inr5_ff <= (xm <= 52'(axis_a_ff)) && (ym <= 52'(axis_b_ff));
         x5_ff   <= xm[AXIS_W-1:0];
         y5_ff   <= ym[AXIS_W-1:0];
         xb6_ff  <= 54'(x5_ff) * 54'(axis_b_ff);
         ya6_ff  <= 54'(y5_ff) * 54'(axis_a_ff);
         ab6_ff  <= 54'(axis_a_ff) * 54'(axis_b_ff);
         lhs9_ff <= 109'(xb2_w) + 109'(ya2_w);
         rhs9_ff <= ab2_w;
         in10_ff <= inr9_w && (lhs9_ff <= 109'(rhs9_ff));
      end
   end

   egq_mulw #(.W(54)) u_sq_xb (.clock, .en, .op_a(xb6_ff), .op_b(xb6_ff), .prod(xb2_w));
   egq_mulw #(.W(54)) u_sq_ya (.clock, .en, .op_a(ya6_ff), .op_b(ya6_ff), .prod(ya2_w));
   egq_mulw #(.W(54)) u_sq_ab (.clock, .en, .op_a(ab6_ff), .op_b(ab6_ff), .prod(ab2_w));

   egq_delay #(.W(1), .D(T_LHS - T_INR)) u_dly_inr (
      .clock, .en, .din(inr5_ff), .dout(inr9_w));
   egq_delay #(.W(1), .D(S_QUO - T_IN)) u_dly_in (
      .clock, .en, .din(in10_ff), .dout(in66_w));

   // bounding box path
   logic [ROT_W-1:0]  mc2_ff, ms2_ff;
   logic [44:0]       u1_3_ff, v1_3_ff, u2_3_ff, v2_3_ff;
   logic [89:0]       u1sq_w, v1sq_w, u2sq_w, v2sq_w;
   logic [SQB_W-1:0]  nx6_ff, ny6_ff;
   logic [SQB_R-1:0]  rootx_w, rooty_w, hx, hy;
   logic [63:0]       t50_w;
   logic signed [COORD_W-1:0] tx50, ty50;
   logic [127:0]      box51_ff, box66_w;

   assign tx50 = $signed(t50_w[63:32]);
   assign ty50 = $signed(t50_w[31:0]);
   assign hx   = rootx_w >> FRAC_BITS;
   assign hy   = rooty_w >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         mc2_ff   <= c1_ff[ROT_W-1] ? ROT_W'(-c1_ff) : ROT_W'(c1_ff);
         ms2_ff   <= s1_ff[ROT_W-1] ? ROT_W'(-s1_ff) : ROT_W'(s1_ff);
         u1_3_ff  <= 45'(mc2_ff) * 45'(axis_a_ff);
         v1_3_ff  <= 45'(ms2_ff) * 45'(axis_b_ff);
         u2_3_ff  <= 45'(ms2_ff) * 45'(axis_a_ff);
         v2_3_ff  <= 45'(mc2_ff) * 45'(axis_b_ff);
         nx6_ff   <= SQB_W'(u1sq_w) + SQB_W'(v1sq_w);
         ny6_ff   <= SQB_W'(u2sq_w) + SQB_W'(v2sq_w);
         box51_ff <= {sat32(SAT_W'(tx50) - $signed(SAT_W'(hx))),
                      sat32(SAT_W'(ty50) - $signed(SAT_W'(hy))),
                      sat32(SAT_W'(tx50) + $signed(SAT_W'(hx))),
                      sat32(SAT_W'(ty50) + $signed(SAT_W'(hy)))};
      end
   end

   egq_mulw #(.W(45)) u_sq_u1 (.clock, .en, .op_a(u1_3_ff), .op_b(u1_3_ff), .prod(u1sq_w));
   egq_mulw #(.W(45)) u_sq_v1 (.clock, .en, .op_a(v1_3_ff), .op_b(v1_3_ff), .prod(v1sq_w));
   egq_mulw #(.W(45)) u_sq_u2 (.clock, .en, .op_a(u2_3_ff), .op_b(u2_3_ff), .prod(u2sq_w));
   egq_mulw #(.W(45)) u_sq_v2 (.clock, .en, .op_a(v2_3_ff), .op_b(v2_3_ff), .prod(v2sq_w));

   egq_sqrt #(.NW(SQB_W)) u_root_hx (.clock, .en, .radicand(nx6_ff), .root(rootx_w));
   egq_sqrt #(.NW(SQB_W)) u_root_hy (.clock, .en, .radicand(ny6_ff), .root(rooty_w));

   egq_delay #(.W(64), .D(B_ROOT - 1)) u_dly_t (
      .clock, .en, .din({tx1_ff, ty1_ff}), .dout(t50_w));
   egq_delay #(.W(128), .D(S_QUO - B_RES)) u_dly_box (
      .clock, .en, .din(box51_ff), .dout(box66_w));

   // support point path
   logic [COORD_W-1:0] mx2_ff, my2_ff;
   logic [PM_W-1:0]    pm3_ff, qm3_ff, pm4_ff, qm4_ff, por;
   logic [SH_W-1:0]    sh_in, sh4_ff;
   logic               zr4_ff, zr66_w;
   logic [30:0]        p5_ff, q5_ff;
   logic [61:0]        pp6_ff, qq6_ff;
   logic [AP_W-1:0]    ap6_ff, bq6_ff;
   logic [SQS_W-1:0]   n7_ff;
   logic [SQS_R-1:0]   r39_w;
   logic [2*AP_W-1:0]  apbq39_w;
   logic [DIV_Q-1:0]   qx66_w, qy66_w;

   assign por = pm3_ff | qm3_ff;

   always_comb begin
      sh_in = '0;
      for (int k = 0; k <= PM_W - 32; k++) begin
         if (|(por >> (31 + k))) sh_in = SH_W'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx2_ff <= vx1_ff[COORD_W-1] ? COORD_W'(-vx1_ff) : COORD_W'(vx1_ff);
         my2_ff <= vy1_ff[COORD_W-1] ? COORD_W'(-vy1_ff) : COORD_W'(vy1_ff);
         pm3_ff <= PM_W'(axis_a_ff) * PM_W'(mx2_ff);
         qm3_ff <= PM_W'(axis_b_ff) * PM_W'(my2_ff);
         sh4_ff <= sh_in;
         pm4_ff <= pm3_ff;
         qm4_ff <= qm3_ff;
         zr4_ff <= (pm3_ff == '0) && (qm3_ff == '0);
         p5_ff  <= 31'(pm4_ff >> sh4_ff);
         q5_ff  <= 31'(qm4_ff >> sh4_ff);
         pp6_ff <= 62'(p5_ff) * 62'(p5_ff);
         qq6_ff <= 62'(q5_ff) * 62'(q5_ff);
         ap6_ff <= AP_W'(axis_a_ff) * AP_W'(p5_ff);
         bq6_ff <= AP_W'(axis_b_ff) * AP_W'(q5_ff);
         n7_ff  <= SQS_W'(pp6_ff) + SQS_W'(qq6_ff);
      end
   end

   egq_sqrt #(.NW(SQS_W)) u_root_r (.clock, .en, .radicand(n7_ff), .root(r39_w));

   egq_delay #(.W(2*AP_W), .D(S_ROOT - S_AP)) u_dly_apbq (
      .clock, .en, .din({ap6_ff, bq6_ff}), .dout(apbq39_w));
   egq_delay #(.W(1), .D(S_QUO - S_ZR)) u_dly_zr (
      .clock, .en, .din(zr4_ff), .dout(zr66_w));

   egq_div #(.NW(AP_W), .DW(SQS_R), .QW(DIV_Q)) u_div_x (
      .clock, .en, .dividend(apbq39_w[2*AP_W-1:AP_W]), .divisor(r39_w), .quotient(qx66_w));
   egq_div #(.NW(AP_W), .DW(SQS_R), .QW(DIV_Q)) u_div_y (
      .clock, .en, .dividend(apbq39_w[AP_W-1:0]), .divisor(r39_w), .quotient(qy66_w));

   // command and direction signs
   logic [CMD_W+1:0] cs66_w;
   logic [CMD_W-1:0] cmd66;
   logic             nx66, ny66;

   egq_delay #(.W(CMD_W + 2), .D(S_QUO - 1)) u_dly_cmd (
      .clock, .en, .din({cmd1_ff, vx1_ff[COORD_W-1], vy1_ff[COORD_W-1]}), .dout(cs66_w));

   assign cmd66 = cs66_w[CMD_W+1:2];
   assign nx66  = cs66_w[1];
   assign ny66  = cs66_w[0];

   // result register
   logic               out_inside_ff, out_degen_ff;
   logic [COORD_W-1:0] out_x0_ff, out_y0_ff, out_x1_ff, out_y1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_inside_ff <= 1'b0;
         out_degen_ff  <= 1'b0;
         out_x0_ff     <= '0;
         out_y0_ff     <= '0;
         out_x1_ff     <= '0;
         out_y1_ff     <= '0;
         case (cmd66)
            CMD_TEST: begin
               out_inside_ff <= in66_w && !degen_ab;
               out_degen_ff  <= degen_ab;
            end
            CMD_BOX: begin
               out_x0_ff    <= box66_w[127:96];
               out_y0_ff    <= box66_w[95:64];
               out_x1_ff    <= box66_w[63:32];
               out_y1_ff    <= box66_w[31:0];
               out_degen_ff <= degen_ab;
            end
            CMD_SUPPORT: begin
               out_degen_ff <= degen_ab || zr66_w;
               if (!zr66_w) begin
                  out_x0_ff <= nx66 ? -COORD_W'(qx66_w) : COORD_W'(qx66_w);
                  out_y0_ff <= ny66 ? -COORD_W'(qy66_w) : COORD_W'(qy66_w);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid      = vld_ff[LAT];
   assign rsp_chan.inside_res = out_inside_ff;
   assign rsp_chan.res_x0     = out_x0_ff;
   assign rsp_chan.res_y0     = out_y0_ff;
   assign rsp_chan.res_x1     = out_x1_ff;
   assign rsp_chan.res_y1     = out_y1_ff;
   assign rsp_chan.degenerate = out_degen_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while result stalled");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("stalled result lost");

   a_inside_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.inside_res |->
         !rsp_chan.degenerate && rsp_chan.res_x1 == '0 && rsp_chan.res_y1 == '0)
      else $error("inside verdict with box or degenerate fields");
endmodule
`default_nettype wire
